// ===== rtl/core/qcil_pkg.sv =====
`timescale 1ns / 1ps
// qcil_pkg: shared widths, word types and the level base function for the
// quadtree cell index lookup. No dependencies.
package qcil_pkg;

	localparam int DEF_MAX_LEVELS = 8;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int POS_W       = 32;  // pos_x, pos_y, origin registers
	localparam int WS_W        = 16;  // world_size
	localparam int LV_W        = 4;   // level, max_level, used_level
	localparam int DIR_W       = 4;   // direction
	localparam int IDX_OUT_W   = 17;  // cell_index
	localparam int COORD_OUT_W = 8;   // cell_x, cell_y
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_DATA_W   = 72;  // 2*32 + 4, padded to bytes
	localparam int OUT_DATA_W  = 40;  // 17 + 8 + 8 + 4, padded to bytes

	// control that travels alongside each word through the divider row
	typedef struct packed {
		logic            valid;
		logic            zero;   // world size of zero: coordinates forced to 0
		logic [LV_W-1:0] lv;
	} ctl_t;

	// one result word, last field (cell_index) in the low bits
	typedef struct packed {
		logic [LV_W-1:0]        used_level;
		logic [COORD_OUT_W-1:0] cell_y;
		logic [COORD_OUT_W-1:0] cell_x;
		logic [IDX_OUT_W-1:0]   cell_index;
	} res_t;

	// first index of a level: (4^lv - 1) / 3 = sum of 4^i for i < lv
	function automatic logic [31:0] tree_base(input logic [LV_W-1:0] lv);
		logic [31:0] acc;
		acc = '0;
		for (int i = 0; i < 15; i++) begin
			if (i < int'(lv)) begin
				acc = acc | (32'd1 << (2 * i));
			end
		end
		return acc;
	endfunction

endpackage

// ===== rtl/core/qcil_div_cell.sv =====
`timescale 1ns / 1ps
// qcil_div_cell: one restoring-division step for both axes, registered.
// Depends on qcil_pkg (ctl_t).
module qcil_div_cell #(
	parameter int WW = 24,  // divisor width
	parameter int QW = 9    // quotient width
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WW-1:0]    w,
	input  qcil_pkg::ctl_t   ctl_in,
	input  logic [WW:0]      rx_in,
	input  logic [WW:0]      ry_in,
	input  logic [QW-1:0]    qx_in,
	input  logic [QW-1:0]    qy_in,
	output qcil_pkg::ctl_t   ctl_out,
	output logic [WW:0]      rx_out,
	output logic [WW:0]      ry_out,
	output logic [QW-1:0]    qx_out,
	output logic [QW-1:0]    qy_out
);
	import qcil_pkg::*;

	logic [WW:0]   w_ext;
	logic          gex, gey;
	logic [WW:0]   rxd, ryd;
	ctl_t          ctl_q;
	logic [WW:0]   rx_q, ry_q;
	logic [QW-1:0] qx_q, qy_q;

	assign w_ext = {1'b0, w};
	assign gex   = rx_in >= w_ext;
	assign gey   = ry_in >= w_ext;
	assign rxd   = gex ? rx_in - w_ext : rx_in;
	assign ryd   = gey ? ry_in - w_ext : ry_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// remainder stays below w, so the doubled value fits WW+1 bits
	always_ff @(posedge clk) begin
		if (en) begin
			rx_q <= {rxd[WW-1:0], 1'b0};
			ry_q <= {ryd[WW-1:0], 1'b0};
			qx_q <= {qx_in[QW-2:0], gex};
			qy_q <= {qy_in[QW-2:0], gey};
		end
	end

	assign ctl_out = ctl_q;
	assign rx_out  = rx_q;
	assign ry_out  = ry_q;
	assign qx_out  = qx_q;
	assign qy_out  = qy_q;

endmodule

// ===== rtl/core/qcil_out_buf.sv =====
`timescale 1ns / 1ps
// qcil_out_buf: output register plus skid register for the result word.
// Depends on qcil_pkg (res_t).
module qcil_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qcil_pkg::res_t in_res,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output qcil_pkg::res_t out_res
);
	import qcil_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic take;

	assign in_ready = !skid_valid_q;
	assign take     = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (take) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// ===== rtl/core/quadtree_cell_index_lookup.sv =====
`timescale 1ns / 1ps
// quadtree_cell_index_lookup: top level. Uses qcil_pkg, qcil_div_cell and
// qcil_out_buf.
//
// Finds the flat index of the quadtree cell that holds a point at a given
// level, optionally stepping 1.5 cells toward a compass neighbor first.
// Input words (s_*): tdata = pos_x, pos_y, level; tuser = direction.
// Result words (m_*): tdata = cell_index, cell_x, cell_y, used_level.
// Configuration: cfg_we/cfg_index/cfg_data, written only while idle by the user
// (not enforced here); index 0 origin_x, 1 origin_y, 2 world_size, 3 max_level.
//
// Throughput: one word per cycle while the output is not stalled. The divider
// row has MAX_LEVELS + 1 cells, one quotient bit per cell; the stages in order
// are s1, s2, s3, the divider cells, sf and the output register.
// A result waiting at the output does not stop input: a skid register
// absorbs one more word, and only then does the whole pipeline hold and
// s_tready drop. Reset clears all valid bits and loads the register
// defaults (origin 0, world size 256, max level 8); no clearing pass.
module quadtree_cell_index_lookup #(
	parameter int MAX_LEVELS = qcil_pkg::DEF_MAX_LEVELS,
	parameter int FRAC_BITS  = qcil_pkg::DEF_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] pos_x, [63:32] pos_y, [67:64] level, rest zero
	input  logic [qcil_pkg::IN_DATA_W-1:0]   s_tdata,
	// [3:0] direction
	input  logic [qcil_pkg::DIR_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [16:0] cell_index, [24:17] cell_x, [32:25] cell_y, [36:33] used_level
	output logic [qcil_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [qcil_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qcil_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import qcil_pkg::*;

	localparam int WW = WS_W + FRAC_BITS;                 // world side, fixed point
	localparam int DW = WW + 2;                           // 3 * world side
	localparam int PW = ((DW > POS_W) ? DW : POS_W) + 2;  // moved position
	localparam int QW = MAX_LEVELS + 1;                   // quotient bits
	localparam int NC = MAX_LEVELS + 1;                   // divider cells
	localparam int CW = (MAX_LEVELS > COORD_OUT_W) ? MAX_LEVELS : COORD_OUT_W;
	localparam int IW = (2 * MAX_LEVELS + 1 > IDX_OUT_W) ? 2 * MAX_LEVELS + 1 : IDX_OUT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 2'd0,
		REG_ORIGIN_Y   = 2'd1,
		REG_WORLD_SIZE = 2'd2,
		REG_MAX_LEVEL  = 2'd3
	} reg_idx_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE = 4'd0,
		DIR_N    = 4'd1,
		DIR_NE   = 4'd2,
		DIR_E    = 4'd3,
		DIR_SE   = 4'd4,
		DIR_S    = 4'd5,
		DIR_SW   = 4'd6,
		DIR_WEST = 4'd7,
		DIR_NW   = 4'd8
	} dir_t;

	// ---------------- configuration registers ----------------
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [WS_W-1:0]         world_size_q;
	logic [LV_W-1:0]         max_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			world_size_q <= WS_W'(256);
			max_level_q  <= LV_W'(8);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:   origin_x_q   <= cfg_data[POS_W-1:0];
				REG_ORIGIN_Y:   origin_y_q   <= cfg_data[POS_W-1:0];
				REG_WORLD_SIZE: world_size_q <= cfg_data[WS_W-1:0];
				REG_MAX_LEVEL:  max_level_q  <= cfg_data[LV_W-1:0];
				default: ;
			endcase
		end
	end

	// world side in fixed point; the user keeps it static while words are in flight (not enforced)
	logic [WW-1:0] w;
	logic [DW-1:0] w3;
	assign w  = WW'(world_size_q) << FRAC_BITS;
	assign w3 = (DW'(w) << 1) + DW'(w);

	logic en;  // whole pipeline advances

	// ---------------- s1: level clamp, neighbor step ----------------
	logic [POS_W-1:0] in_px, in_py;
	logic [LV_W-1:0]  in_lv, lv_a, lv_c;
	logic             xp, xn, yp, yn;

	assign in_px = s_tdata[POS_W-1:0];
	assign in_py = s_tdata[2*POS_W-1:POS_W];
	assign in_lv = s_tdata[2*POS_W+LV_W-1:2*POS_W];
	assign lv_a  = (in_lv > max_level_q) ? max_level_q : in_lv;
	assign lv_c  = (lv_a > LV_W'(MAX_LEVELS)) ? LV_W'(MAX_LEVELS) : lv_a;

	// north is decreasing y
	always_comb begin
		xp = 1'b0;
		xn = 1'b0;
		yp = 1'b0;
		yn = 1'b0;
		case (dir_t'(s_tuser))
			DIR_N:  yn = 1'b1;
			DIR_NE: begin
				yn = 1'b1;
				xp = 1'b1;
			end
			DIR_E:  xp = 1'b1;
			DIR_SE: begin
				yp = 1'b1;
				xp = 1'b1;
			end
			DIR_S:  yp = 1'b1;
			DIR_SW: begin
				yp = 1'b1;
				xn = 1'b1;
			end
			DIR_WEST: xn = 1'b1;
			DIR_NW: begin
				yn = 1'b1;
				xn = 1'b1;
			end
			default: ;
		endcase
	end

	logic                    v_s1;
	logic signed [POS_W-1:0] px_s1, py_s1;
	logic [DW-1:0]           d_s1;
	logic [LV_W-1:0]         lv_s1;
	logic                    xp_s1, xn_s1, yp_s1, yn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_px;
			py_s1 <= in_py;
			d_s1  <= w3 >> (lv_c + 1'b1);  // 1.5 cells at this level
			lv_s1 <= lv_c;
			xp_s1 <= xp;
			xn_s1 <= xn;
			yp_s1 <= yp;
			yn_s1 <= yn;
		end
	end

	// ---------------- s2: move the point ----------------
	logic signed [PW-1:0] px_e, py_e, d_e;
	logic signed [PW-1:0] mx, my;

	assign px_e = PW'(px_s1);
	assign py_e = PW'(py_s1);
	assign d_e  = $signed(PW'(d_s1));

	always_comb begin
		mx = px_e;
		if (xp_s1) begin
			mx = px_e + d_e;
		end else if (xn_s1) begin
			mx = px_e - d_e;
		end
		my = py_e;
		if (yp_s1) begin
			my = py_e + d_e;
		end else if (yn_s1) begin
			my = py_e - d_e;
		end
	end

	logic                 v_s2;
	logic signed [PW-1:0] mx_s2, my_s2;
	logic [LV_W-1:0]      lv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2 <= mx;
			my_s2 <= my;
			lv_s2 <= lv_s1;
		end
	end

	// ---------------- s3: clamp to world, subtract origin ----------------
	logic signed [PW:0] difx, dify, w_s;
	logic [WW-1:0]      offx, offy;

	assign w_s  = $signed({{(PW + 1 - WW){1'b0}}, w});
	assign difx = (PW + 1)'(mx_s2) - (PW + 1)'(origin_x_q);
	assign dify = (PW + 1)'(my_s2) - (PW + 1)'(origin_y_q);

	// clamping the point to [origin, origin + w] is clamping the offset to [0, w]
	always_comb begin
		if (difx < 0) begin
			offx = '0;
		end else if (difx > w_s) begin
			offx = w;
		end else begin
			offx = difx[WW-1:0];
		end
		if (dify < 0) begin
			offy = '0;
		end else if (dify > w_s) begin
			offy = w;
		end else begin
			offy = dify[WW-1:0];
		end
	end

	ctl_t          ctl_s3;
	logic [WW-1:0] offx_s3, offy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3.valid <= v_s2;
			ctl_s3.zero  <= (world_size_q == '0);
			ctl_s3.lv    <= lv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offx_s3 <= offx;
			offy_s3 <= offy;
		end
	end

	// ---------------- divider row: Q = floor(off * 2^MAX_LEVELS / w) ----------------
	// off <= w, so Q fits MAX_LEVELS + 1 bits; each cell yields one bit, MSB first.
	ctl_t          ctl_c [NC+1];
	logic [WW:0]   rx_c  [NC+1];
	logic [WW:0]   ry_c  [NC+1];
	logic [QW-1:0] qx_c  [NC+1];
	logic [QW-1:0] qy_c  [NC+1];

	assign ctl_c[0] = ctl_s3;
	assign rx_c[0]  = (WW + 1)'(offx_s3);
	assign ry_c[0]  = (WW + 1)'(offy_s3);
	assign qx_c[0]  = '0;
	assign qy_c[0]  = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		qcil_div_cell #(
			.WW(WW),
			.QW(QW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.w       (w),
			.ctl_in  (ctl_c[k]),
			.rx_in   (rx_c[k]),
			.ry_in   (ry_c[k]),
			.qx_in   (qx_c[k]),
			.qy_in   (qy_c[k]),
			.ctl_out (ctl_c[k+1]),
			.rx_out  (rx_c[k+1]),
			.ry_out  (ry_c[k+1]),
			.qx_out  (qx_c[k+1]),
			.qy_out  (qy_c[k+1])
		);
	end

	// ---------------- sf: scale to level, clamp to last cell ----------------
	// floor(off * 2^lv / w) = Q >> (MAX_LEVELS - lv)
	ctl_t          ctl_end;
	logic [LV_W-1:0] sh;
	logic [QW-1:0] cqx, cqy, lim;
	logic [CW-1:0] cx, cy;

	assign ctl_end = ctl_c[NC];
	assign sh      = LV_W'(MAX_LEVELS) - ctl_end.lv;
	assign cqx     = qx_c[NC] >> sh;
	assign cqy     = qy_c[NC] >> sh;
	assign lim     = (QW'(1) << ctl_end.lv) - QW'(1);

	always_comb begin
		cx = CW'((cqx > lim) ? lim : cqx);
		cy = CW'((cqy > lim) ? lim : cqy);
		if (ctl_end.zero) begin
			cx = '0;
			cy = '0;
		end
	end

	logic            v_sf;
	logic [CW-1:0]   cx_sf, cy_sf;
	logic [LV_W-1:0] lv_sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= ctl_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_sf <= cx;
			cy_sf <= cy;
			lv_sf <= ctl_end.lv;
		end
	end

	// ---------------- flat index and output buffer ----------------
	logic [IW-1:0] idx;
	res_t          res, out_res;

	assign idx = IW'(tree_base(lv_sf)) + IW'(cx_sf) + (IW'(cy_sf) << lv_sf);

	always_comb begin
		res.cell_index = idx[IDX_OUT_W-1:0];
		res.cell_x     = cx_sf[COORD_OUT_W-1:0];
		res.cell_y     = cy_sf[COORD_OUT_W-1:0];
		res.used_level = lv_sf;
	end

	qcil_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_sf),
		.in_res    (res),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign s_tready = en;
	assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_res};

endmodule

// ===== tb/sv/quadtree_cell_index_lookup_test.sv =====
`timescale 1ns / 1ps
// quadtree_cell_index_lookup_test: self-checking bench for the quadtree cell
// index lookup. Uses qcil_pkg and the quadtree_cell_index_lookup RTL only.
// A directed table, then randomized phases; typed-in results or a predictor check each word.
module quadtree_cell_index_lookup_test;

	import qcil_pkg::*;

	// register map of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = 2'd3;

	// neighbor directions; north is decreasing y, codes past NW mean no move
	localparam logic [DIR_W-1:0] DIR_NONE      = 4'd0;
	localparam logic [DIR_W-1:0] DIR_N         = 4'd1;
	localparam logic [DIR_W-1:0] DIR_NE        = 4'd2;
	localparam logic [DIR_W-1:0] DIR_E         = 4'd3;
	localparam logic [DIR_W-1:0] DIR_SE        = 4'd4;
	localparam logic [DIR_W-1:0] DIR_S         = 4'd5;
	localparam logic [DIR_W-1:0] DIR_SW        = 4'd6;
	localparam logic [DIR_W-1:0] DIR_WEST      = 4'd7;
	localparam logic [DIR_W-1:0] DIR_NW        = 4'd8;
	localparam logic [DIR_W-1:0] DIR_UNUSED_LO = 4'd9;
	localparam logic [DIR_W-1:0] DIR_UNUSED_HI = 4'd15;

	localparam int LEVELS       = DEF_MAX_LEVELS;
	localparam int FRAC         = DEF_FRAC_BITS;
	localparam int LATENCY      = LEVELS + 5;
	localparam int HOLD_CYCLES  = 90;      // long receiver hold-off
	localparam int PHASES       = 7;
	localparam int PHASE_WORDS  = 150;
	localparam int LIMIT_CYCLES = 400000;

	// one row of the directed table: a register write or a query word
	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] sel;
		logic [31:0]          wdata;
		logic [31:0]          px;
		logic [31:0]          py;
		logic [LV_W-1:0]      lv;
		logic [DIR_W-1:0]     dir;
		bit                   known;   // expected result typed in below
		res_t                 want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;   // [31:0] pos_x, [63:32] pos_y, [67:64] level
	logic [DIR_W-1:0]       s_tuser;   // [3:0] direction
	logic                   m_tvalid;
	logic                   m_tready;
	// [16:0] cell_index, [24:17] cell_x, [32:25] cell_y, [36:33] used_level
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// shadow of the block's registers, changed only while it is idle
	logic [31:0]      cfg_origin_x;
	logic [31:0]      cfg_origin_y;
	logic [WS_W-1:0]  cfg_world_size;
	logic [LV_W-1:0]  cfg_max_level;

	res_t pending_cells[$];    // expected result words, oldest first
	row_t plan[$];
	int   fail_count;
	int   send_gap_pct;
	int   recv_stall_pct;
	logic rx_hold;
	int   cycle_count;
	event hold_go;

	quadtree_cell_index_lookup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// cell column or row on one axis: clamp to the world square, take the
	// offset, scale by 2^level, divide by the world side, clamp to the last cell
	function automatic longint unsigned axis_cell(longint p, longint org, longint w, int ul);
		longint          off;
		longint unsigned c;
		longint unsigned last;
		if (w == 0) begin
			return 0;
		end
		off = (p < org) ? org : p;
		if (off > org + w) begin
			off = org + w;
		end
		off = off - org;
		c = longint'(off << ul) / w;
		last = (longint'(1) << ul) - 1;
		return (c > last) ? last : c;
	endfunction

	function automatic res_t locate_cell(logic [31:0] px, logic [31:0] py,
	                                     logic [LV_W-1:0] lv, logic [DIR_W-1:0] dir);
		int              ul;
		int              dx;
		int              dy;
		longint          w;
		longint          step;
		longint          x;
		longint          y;
		longint unsigned cx;
		longint unsigned cy;
		longint unsigned base;
		res_t            r;
		ul = int'(lv);
		if (ul > int'(cfg_max_level)) begin
			ul = int'(cfg_max_level);
		end
		if (ul > LEVELS) begin
			ul = LEVELS;
		end
		w = longint'(cfg_world_size) << FRAC;
		step = (3 * w) >> (ul + 1);   // 1.5 cells at this level
		dx = 0;
		dy = 0;
		case (dir)
			DIR_N:  begin dy = -1; end
			DIR_NE: begin dy = -1; dx = 1; end
			DIR_E:  begin dx = 1; end
			DIR_SE: begin dy = 1; dx = 1; end
			DIR_S:  begin dy = 1; end
			DIR_SW: begin dy = 1; dx = -1; end
			DIR_WEST: begin dx = -1; end
			DIR_NW: begin dy = -1; dx = -1; end
			default: begin end
		endcase
		x = longint'(signed'(px)) + dx * step;
		y = longint'(signed'(py)) + dy * step;
		cx = axis_cell(x, longint'(signed'(cfg_origin_x)), w, ul);
		cy = axis_cell(y, longint'(signed'(cfg_origin_y)), w, ul);
		base = ((longint'(1) << (2 * ul)) - 1) / 3;
		r.cell_index = IDX_OUT_W'(base + cx + (cy << ul));
		r.cell_x     = COORD_OUT_W'(cx);
		r.cell_y     = COORD_OUT_W'(cy);
		r.used_level = LV_W'(ul);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------

	function automatic row_t write_row(logic [CFG_IDX_W-1:0] sel, logic [31:0] value);
		row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.sel = sel;
		r.wdata = value;
		return r;
	endfunction

	function automatic row_t query_row(logic [31:0] px, logic [31:0] py,
	                                   logic [LV_W-1:0] lv, logic [DIR_W-1:0] dir);
		row_t r;
		r = '{default: '0};
		r.px = px;
		r.py = py;
		r.lv = lv;
		r.dir = dir;
		return r;
	endfunction

	function automatic row_t known_row(logic [31:0] px, logic [31:0] py,
	                                   logic [LV_W-1:0] lv, logic [DIR_W-1:0] dir,
	                                   int idx, int cx, int cy, int ul);
		row_t r;
		r = query_row(px, py, lv, dir);
		r.known = 1'b1;
		r.want.cell_index = IDX_OUT_W'(idx);
		r.want.cell_x     = COORD_OUT_W'(cx);
		r.want.cell_y     = COORD_OUT_W'(cy);
		r.want.used_level = LV_W'(ul);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// offer one query word, with random idle cycles first; the expectation
	// is queued at the edge that accepts the word
	task automatic offer_word(logic [31:0] px, logic [31:0] py, logic [LV_W-1:0] lv,
	                          logic [DIR_W-1:0] dir, bit known, res_t want);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({lv, py, px});
		s_tuser  <= dir;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pending_cells.push_back(known ? want : locate_cell(px, py, lv, dir));
	endtask

	// stop sending and wait until every expected word has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY) @(posedge clk);
	endtask

	// write enable is lowered in its own cycle so back-to-back writes never
	// raise and lower it in the same step
	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		case (sel)
			REG_ORIGIN_X:   cfg_origin_x   = value;
			REG_ORIGIN_Y:   cfg_origin_y   = value;
			REG_WORLD_SIZE: cfg_world_size = value[WS_W-1:0];
			REG_MAX_LEVEL:  cfg_max_level  = value[LV_W-1:0];
			default: begin end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random query: mostly around the world square, some right on cell
	// borders, the rest anywhere in the 32-bit range
	task automatic random_query(output logic [31:0] px, output logic [31:0] py,
	                            output logic [LV_W-1:0] lv, output logic [DIR_W-1:0] dir);
		longint w;
		longint ox;
		longint oy;
		int     kind;
		int     ul;
		longint span;
		w = longint'(cfg_world_size) << FRAC;
		ox = longint'(signed'(cfg_origin_x));
		oy = longint'(signed'(cfg_origin_y));
		lv = ($urandom_range(0, 99) < 30) ? LV_W'($urandom_range(0, 15))
		                                   : LV_W'($urandom_range(0, LEVELS));
		dir = ($urandom_range(0, 99) < 25) ? DIR_W'($urandom_range(0, 15))
		                                    : DIR_W'($urandom_range(0, 8));
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			px = $urandom;
			py = $urandom;
		end else if (kind < 35) begin
			ul = int'(lv);
			if (ul > int'(cfg_max_level)) ul = int'(cfg_max_level);
			if (ul > LEVELS) ul = LEVELS;
			px = 32'(ox + ((longint'($urandom_range(0, (1 << ul) - 1)) * w) >> ul)
			         + $urandom_range(0, 4) - 2);
			py = 32'(oy + ((longint'($urandom_range(0, (1 << ul) - 1)) * w) >> ul)
			         + $urandom_range(0, 4) - 2);
		end else begin
			span = w + w / 4;
			px = 32'(ox + longint'($urandom_range(0, 32'(span))) - w / 8);
			py = 32'(oy + longint'($urandom_range(0, 32'(span))) - w / 8);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, long hold-off, field-by-field check
	// ------------------------------------------------------------------

	task automatic report_field(string name, int want, int got);
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
	endtask

	initial begin
		forever begin
			@(hold_go);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		res_t got;
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				if (pending_cells.size() == 0) begin
					$display("%0t: unexpected word, expected none got %h", $time, m_tdata);
					fail_count++;
				end else begin
					want = pending_cells.pop_front();
					if (got !== want) begin
						fail_count++;
						if (got.cell_index !== want.cell_index)
							report_field("cell_index", want.cell_index, got.cell_index);
						if (got.cell_x !== want.cell_x)
							report_field("cell_x", want.cell_x, got.cell_x);
						if (got.cell_y !== want.cell_y)
							report_field("cell_y", want.cell_y, got.cell_y);
						if (got.used_level !== want.used_level)
							report_field("used_level", want.used_level, got.used_level);
					end
				end
			end
			m_tready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** quadtree_cell_index_lookup: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		logic [31:0]     px;
		logic [31:0]     py;
		logic [LV_W-1:0] lv;
		logic [DIR_W-1:0] dir;
		res_t            none;
		logic [31:0]     ox;
		logic [31:0]     oy;
		logic [31:0]     ws;
		logic [31:0]     ml;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_hold = 1'b0;
		fail_count = 0;
		send_gap_pct = 25;
		recv_stall_pct = 61;
		none = '0;
		// register defaults after reset
		cfg_origin_x = 32'd0;
		cfg_origin_y = 32'd0;
		cfg_world_size = 16'd256;
		cfg_max_level = 4'd8;

		// default world: side 256 units = 65536 in fixed point, max level 8
		plan.push_back(known_row(32'd0, 32'd0, 4'd0, DIR_NONE, 0, 0, 0, 0));
		// far corner past the world, level above the maximum: last cell of level 8
		plan.push_back(known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, DIR_NONE,
		                         87380, 255, 255, 8));
		plan.push_back(known_row(32'h8000_0000, 32'h8000_0000, 4'd8, DIR_NONE,
		                         21845, 0, 0, 8));
		plan.push_back(known_row(32'h0000_8000, 32'h0000_8000, 4'd1, DIR_NONE, 4, 1, 1, 1));
		plan.push_back(query_row(32'hFFFF_FFFF, 32'h0001_0000, 4'd4, DIR_NONE));
		plan.push_back(query_row(32'h0000_FFFF, 32'h0000_00FF, 4'd8, DIR_NONE));
		// every neighbor from cell (1,1) of level 2, and the unused codes
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_N));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_NE));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_E));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_SE));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_S));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_SW));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_WEST));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_NW));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_UNUSED_LO));
		plan.push_back(query_row(32'd16384, 32'd16384, 4'd2, DIR_UNUSED_HI));
		// max level past the tree depth still clamps to 8
		plan.push_back(write_row(REG_MAX_LEVEL, 32'd15));
		plan.push_back(known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, DIR_NONE,
		                         87380, 255, 255, 8));
		plan.push_back(write_row(REG_MAX_LEVEL, 32'd3));
		plan.push_back(known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, DIR_NONE, 84, 7, 7, 3));
		// zero world size: coordinates forced to 0, level base only
		plan.push_back(write_row(REG_WORLD_SIZE, 32'd0));
		plan.push_back(known_row(32'h0000_1234, 32'h0000_5678, 4'd2, DIR_NONE, 5, 0, 0, 2));
		plan.push_back(query_row(32'h0000_1234, 32'h0000_5678, 4'd2, DIR_SE));
		// extreme origins with the largest world
		plan.push_back(write_row(REG_ORIGIN_X, 32'h8000_0000));
		plan.push_back(write_row(REG_ORIGIN_Y, 32'h7FFF_FFFF));
		plan.push_back(write_row(REG_WORLD_SIZE, 32'd65535));
		plan.push_back(write_row(REG_MAX_LEVEL, 32'd8));
		plan.push_back(known_row(32'h8000_0000, 32'h7FFF_FFFF, 4'd8, DIR_NONE,
		                         21845, 0, 0, 8));
		plan.push_back(known_row(32'h7FFF_FFFF, 32'h8000_0000, 4'd8, DIR_NONE,
		                         22100, 255, 0, 8));
		plan.push_back(query_row(32'h8000_0000, 32'h7FFF_FFFF, 4'd8, DIR_SE));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain();
				write_reg(plan[i].sel, plan[i].wdata);
			end else begin
				offer_word(plan[i].px, plan[i].py, plan[i].lv, plan[i].dir,
				           plan[i].known, plan[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			// idle mix: sender light / receiver heavy, then swapped, then none
			if (p < 3) begin
				send_gap_pct = 25;
				recv_stall_pct = 61;
			end else if (p < 5) begin
				send_gap_pct = 61;
				recv_stall_pct = 25;
			end else begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			case (p)
				0: begin ox = 32'd0; oy = 32'd0; ws = 32'd256; ml = 32'd8; end
				1: begin ox = 32'h8000_0000; oy = 32'h7FFF_FFFF; ws = 32'd65535; ml = 32'd8; end
				2: begin ox = $urandom; oy = $urandom; ws = 32'd1; ml = 32'd0; end
				3: begin
					ox = $urandom;
					oy = $urandom;
					ws = $urandom_range(2, 400);
					ml = $urandom_range(1, LEVELS);
				end
				4: begin ox = 32'h7FFF_FFFF; oy = 32'h8000_0000; ws = 32'd3; ml = 32'd15; end
				5: begin
					ox = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
					oy = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
					ws = $urandom_range(1, 65535);
					ml = 32'd8;
				end
				default: begin
					ox = $urandom;
					oy = $urandom;
					ws = $urandom_range(0, 65535);
					ml = $urandom_range(0, 15);
				end
			endcase
			write_reg(REG_ORIGIN_X, ox);
			write_reg(REG_ORIGIN_Y, oy);
			write_reg(REG_WORLD_SIZE, ws);
			write_reg(REG_MAX_LEVEL, ml);
			// with no idling, a long hold-off fills the pipe and stalls input
			if (p == 5) begin
				-> hold_go;
			end
			repeat (PHASE_WORDS) begin
				random_query(px, py, lv, dir);
				offer_word(px, py, lv, dir, 1'b0, none);
			end
		end

		drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("** quadtree_cell_index_lookup: PASSED **");
		end else begin
			$display("** quadtree_cell_index_lookup: FAILED **");
		end
		$finish;
	end

endmodule
